### rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants for the Gregorian date adder
// Field widths, payload structs and the month-length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int ADD_W  = 20;

  // Only the low ADD_DAYS_WIDTH bits of the day count are used (8..20).
  localparam int ADD_DAYS_WIDTH = 20;

  // The ordinal holds the day count plus up to one year of days.
  localparam int ORD_W = ((ADD_DAYS_WIDTH > 9) ? ADD_DAYS_WIDTH : 9) + 1;
  localparam int YLEN_W = 9;

  localparam logic [YEAR_W-1:0] MAX_YEAR   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0] ERA_YEARS  = YEAR_W'(400);
  localparam logic [YEAR_W-1:0] CENT_1     = YEAR_W'(100);
  localparam logic [YEAR_W-1:0] CENT_2     = YEAR_W'(200);
  localparam logic [YEAR_W-1:0] CENT_3     = YEAR_W'(300);
  localparam logic [YEAR_W-1:0] ERA_LAST   = YEAR_W'(399);
  localparam logic [YLEN_W-1:0] LEAP_YLEN  = YLEN_W'(366);
  localparam logic [YLEN_W-1:0] COMMON_YLEN = YLEN_W'(365);
  localparam logic [MON_W-1:0]  MON_JAN    = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_DEC    = MON_W'(12);
  localparam logic [MON_W-1:0]  MON_IDX_DEC = MON_W'(11);
  localparam logic [DAY_W-1:0]  DAY_FIRST  = DAY_W'(1);
  localparam logic [DAY_W-1:0]  DAY_LAST_DEC = DAY_W'(31);

  typedef struct packed {
    logic [YEAR_W-1:0] start_year;
    logic [MON_W-1:0]  start_month;
    logic [DAY_W-1:0]  start_day;
    logic [ADD_W-1:0]  days_to_add;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0] result_year;
    logic [MON_W-1:0]  result_month;
    logic [DAY_W-1:0]  result_day;
    logic              year_overflow;
  } out_item_t;

  // Length of a month given its zero-based index.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MON_W-1:0] idx);
    logic [DAY_W-1:0] len;
    begin
      unique case (idx)
        MON_W'(1): len = leap ? DAY_W'(29) : DAY_W'(28);
        MON_W'(3), MON_W'(5), MON_W'(8), MON_W'(10): len = DAY_W'(30);
        default: len = DAY_W'(31);
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/cda_in_if.sv
// ----------------------------------------------------------------------------
// cda_in_if: input channel of the date adder
// Valid/ready channel that carries one start date and day count.
// ----------------------------------------------------------------------------
`default_nettype none

interface cda_in_if;
  import cda_pkg::*;

  logic               valid;
  logic               ready;
  cda_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/cda_out_if.sv
// ----------------------------------------------------------------------------
// cda_out_if: result channel of the date adder
// Valid/ready channel that carries one resulting date.
// ----------------------------------------------------------------------------
`default_nettype none

interface cda_out_if;
  import cda_pkg::*;

  logic               valid;
  logic               ready;
  cda_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/calendar_date_add_days.sv
// After acceptance the sequencer reduces the year modulo 400, adds the
// lengths of the months before the start, steps whole years, then
// whole months, before the result is registered.
// A new transaction is taken only once the sequencer is idle again; an
// earlier result not yet taken holds the sequencer in ST_FIN.
// Reset: synchronous, active low; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// calendar_date_add_days: Gregorian date plus a day count
// A small sequencer drives one shared adder/subtractor and comparator to
// turn the start date into a day ordinal, step whole years, then months.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days (
  input  logic      clk,
  input  logic      rst_n,
  cda_in_if.sink    in_if,
  cda_out_if.source out_if
);
  import cda_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] ST_MOD  = 3'd1;  // reduce the year modulo 400
  localparam logic [2:0] ST_MSUM = 3'd2;  // add lengths of months before start
  localparam logic [2:0] ST_YEAR = 3'd3;  // take away whole years
  localparam logic [2:0] ST_MON  = 3'd4;  // take away whole months
  localparam logic [2:0] ST_FIN  = 3'd5;  // hand the result to the output reg

  logic [2:0]        state_r, state_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  // Year modulo 400; it holds the raw year only while ST_MOD reduces it.
  logic [YEAR_W-1:0] rem_r, rem_nxt;
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [MON_W-1:0]  midx_r, midx_nxt;
  logic [ORD_W-1:0]  ord_r, ord_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Accept-time clamping of the start date.
  logic [MON_W-1:0]  mon_clamp;
  logic [DAY_W-1:0]  day_clamp;
  logic              accept;
  logic              out_free;

  // Leap rule from the running remainder: divisible by 4 and not a
  // century unless the century is a multiple of 400.
  logic              leap;
  logic [YLEN_W-1:0] ylen;
  logic [DAY_W-1:0]  mlen;

  // Shared arithmetic unit: one operand select, one adder, one subtractor
  // and one compare against the running ordinal.
  logic [ORD_W-1:0]  alu_b;
  logic [ORD_W-1:0]  alu_sum;
  logic [ORD_W-1:0]  alu_diff;
  logic              alu_gt;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    mon_clamp = in_if.data.start_month;
    if (in_if.data.start_month < MON_JAN) begin
      mon_clamp = MON_JAN;
    end else if (in_if.data.start_month > MON_DEC) begin
      mon_clamp = MON_DEC;
    end
    day_clamp = (in_if.data.start_day == '0) ? DAY_FIRST : in_if.data.start_day;
  end

  assign leap = (year_r[1:0] == 2'b00) && (rem_r != CENT_1) &&
                (rem_r != CENT_2) && (rem_r != CENT_3);
  assign ylen = leap ? LEAP_YLEN : COMMON_YLEN;
  assign mlen = month_len(leap, midx_r);

  assign alu_b    = (state_r == ST_YEAR) ? ORD_W'(ylen) : ORD_W'(mlen);
  assign alu_sum  = ord_r + alu_b;
  assign alu_diff = ord_r - alu_b;
  assign alu_gt   = ord_r > alu_b;

  always_comb begin
    state_nxt     = state_r;
    year_nxt      = year_r;
    rem_nxt       = rem_r;
    mon_nxt       = mon_r;
    midx_nxt      = midx_r;
    ord_nxt       = ord_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // A waiting result leaves once the sink takes it.
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          year_nxt = in_if.data.start_year;
          rem_nxt  = in_if.data.start_year;
          mon_nxt  = mon_clamp;
          midx_nxt = '0;
          ord_nxt  = ORD_W'(day_clamp) +
                     ORD_W'(in_if.data.days_to_add[ADD_DAYS_WIDTH-1:0]);
          // A start year outside the range goes straight to saturation.
          ovf_nxt   = in_if.data.start_year > MAX_YEAR;
          state_nxt = (in_if.data.start_year > MAX_YEAR) ? ST_FIN : ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_r >= ERA_YEARS) begin
          rem_nxt = rem_r - ERA_YEARS;
        end else begin
          state_nxt = ST_MSUM;
        end
      end
      ST_MSUM: begin
        if ((midx_r + MON_W'(1)) < mon_r) begin
          ord_nxt  = alu_sum;
          midx_nxt = midx_r + MON_W'(1);
        end else begin
          midx_nxt  = '0;
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (alu_gt) begin
          ord_nxt = alu_diff;
          if (year_r == MAX_YEAR) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            year_nxt = year_r + YEAR_W'(1);
            rem_nxt  = (rem_r == ERA_LAST) ? '0 : rem_r + YEAR_W'(1);
          end
        end else begin
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if ((midx_r < MON_IDX_DEC) && alu_gt) begin
          ord_nxt  = alu_diff;
          midx_nxt = midx_r + MON_W'(1);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here only if an earlier result has not been taken yet.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_data_nxt.result_year   = MAX_YEAR;
            out_data_nxt.result_month  = MON_DEC;
            out_data_nxt.result_day    = DAY_LAST_DEC;
            out_data_nxt.year_overflow = 1'b1;
          end else begin
            out_data_nxt.result_year   = year_r;
            out_data_nxt.result_month  = midx_r + MON_W'(1);
            out_data_nxt.result_day    = ord_r[DAY_W-1:0];
            out_data_nxt.year_overflow = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Datapath registers carry no reset; the sequencer qualifies them.
  always_ff @(posedge clk) begin
    year_r     <= year_nxt;
    rem_r      <= rem_nxt;
    mon_r      <= mon_nxt;
    midx_r     <= midx_nxt;
    ord_r      <= ord_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new transaction is taken only when the sequencer is free; the output
  // register lets it start while the previous result still waits.
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // An overflowing result always carries the saturated last date.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.year_overflow) |->
      (out_data_r.result_year == MAX_YEAR && out_data_r.result_month == MON_DEC &&
       out_data_r.result_day == DAY_LAST_DEC))
    else $error("overflow result is not 9999-12-31");

  // Once the modulo reduction is done, the remainder stays below 400.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MSUM || state_r == ST_YEAR || state_r == ST_MON) |->
      (rem_r < ERA_YEARS))
    else $error("year remainder out of range");

  // The year being stepped never leaves the supported range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR || state_r == ST_MON) |-> (year_r <= MAX_YEAR))
    else $error("working year past the maximum");

  // A regular result is a real calendar month with a nonzero day.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.year_overflow) |->
      (out_data_r.result_month >= MON_JAN && out_data_r.result_month <= MON_DEC &&
       out_data_r.result_day != '0))
    else $error("result date is malformed");

  // An accepted transaction keeps the input closed on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("input reopened right after a transaction");

endmodule

`default_nettype wire

### sim/tb_calendar_date_add_days.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_add_days: self-checking bench for the Gregorian date adder
// Drives start dates and day counts through the valid/ready input channel
// and checks every resulting date against a behavioral date calculator
// kept in the bench. Directed cases cover field extremes, clamping of month
// and day, leap-year rules and year overflow. Random traffic follows, with
// idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_add_days;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 10;
  // The worst-case transaction steps through close to 2900 years, so the
  // quiet window at the end covers one full worst-case latency.
  localparam int DRAIN_CYCLES = 3100;
  // Slowest correct run is about 140 worst-case transactions, roughly 9 ms;
  // the limit allows several times that.
  localparam int RUN_LIMIT_NS = 50_000_000;
  localparam int MAX_IDLE     = 18;

  logic clk = 1'b0;
  logic rst_n;

  cda_in_if  in_ch();
  cda_out_if out_ch();

  calendar_date_add_days u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Dates still owed by the block, oldest first.
  out_item_t expected_dates[$];
  int unsigned mismatch_count = 0;
  // When cleared, neither channel inserts idle cycles.
  bit idle_enable = 1'b1;

  // ---------------------------------------------------------------------------
  // Date calculator
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(int unsigned yr);
    return is_leap_year(yr) ? 366 : 365;
  endfunction

  // Length of the month with zero-based index mon_idx.
  function automatic int unsigned days_in_month(bit leap, int unsigned mon_idx);
    int unsigned len;
    case (mon_idx)
      1:           len = leap ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Computes the date that lies days_to_add days after the start date. The
  // start month is clamped into January..December and a zero day becomes the
  // first. A day past the end of its month is not clamped: it simply rolls
  // into the following months, because the date is first turned into a
  // day-of-year ordinal.
  function automatic out_item_t date_after_days(in_item_t item);
    out_item_t    res;
    int unsigned  yr;
    int unsigned  mon;
    int unsigned  dy;
    int unsigned  idx;
    longint unsigned ordinal;
    bit           leap;
    bit           ovf;
    yr  = item.start_year;
    mon = item.start_month;
    dy  = item.start_day;
    ovf = 1'b0;
    if (mon < MON_JAN) mon = MON_JAN;
    if (mon > MON_DEC) mon = MON_DEC;
    if (dy < DAY_FIRST) dy = DAY_FIRST;
    res = '0;

    if (yr > MAX_YEAR) begin
      ovf = 1'b1;
    end else begin
      leap = is_leap_year(yr);
      ordinal = dy;
      for (idx = 0; idx + 1 < mon; idx++) begin
        ordinal += days_in_month(leap, idx);
      end
      ordinal += longint'(item.days_to_add) & ((64'd1 << ADD_DAYS_WIDTH) - 1);

      // Strip whole years; passing the last representable year is overflow.
      while (ordinal > days_in_year(yr)) begin
        ordinal -= days_in_year(yr);
        yr++;
        if (yr > MAX_YEAR) begin
          ovf = 1'b1;
          break;
        end
      end

      if (!ovf) begin
        leap = is_leap_year(yr);
        idx = 0;
        while (idx < MON_IDX_DEC && ordinal > days_in_month(leap, idx)) begin
          ordinal -= days_in_month(leap, idx);
          idx++;
        end
        res.result_year   = YEAR_W'(yr);
        res.result_month  = MON_W'(idx + 1);
        res.result_day    = DAY_W'(ordinal);
        res.year_overflow = 1'b0;
      end
    end

    // Overflow pins the result to the last day of the last year.
    if (ovf) begin
      res.result_year   = MAX_YEAR;
      res.result_month  = MON_DEC;
      res.result_day    = DAY_LAST_DEC;
      res.year_overflow = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every result transaction is compared field by field with the oldest
  // outstanding date. Inputs and outputs are sampled at the rising edge,
  // before any nonblocking update of that edge takes effect.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (expected_dates.size() == 0) begin
        report_mismatch("result with nothing outstanding", got.result_year, 0);
      end else begin
        want = expected_dates.pop_front();
        if (got.result_year !== want.result_year)
          report_mismatch("result_year", got.result_year, want.result_year);
        if (got.result_month !== want.result_month)
          report_mismatch("result_month", got.result_month, want.result_month);
        if (got.result_day !== want.result_day)
          report_mismatch("result_day", got.result_day, want.result_day);
        if (got.year_overflow !== want.year_overflow)
          report_mismatch("year_overflow", got.year_overflow, want.year_overflow);
      end
    end
  end

  // The result side stalls in random bursts while idling is enabled, and
  // otherwise takes every result at once.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, MAX_IDLE) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_date(int unsigned yr, int unsigned mon,
                                         int unsigned dy, int unsigned add_days);
    in_item_t item;
    item.start_year  = YEAR_W'(yr);
    item.start_month = MON_W'(mon);
    item.start_day   = DAY_W'(dy);
    item.days_to_add = ADD_W'(add_days);
    return item;
  endfunction

  // Sends one transaction. Called right after a rising edge; returns right
  // after the edge at which the block accepted it, with valid still high so
  // that back-to-back transactions need no second assignment in one step.
  task automatic send_date(in_item_t item);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_dates.push_back(date_after_days(item));
  endtask

  // Drops valid and holds off until every outstanding date has come back.
  // At least one edge passes so that valid is not raised again in the same step.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  // Mostly well-formed dates with random counts of several magnitudes, plus
  // dates near the top of the year range, month-end days and raw noise.
  function automatic in_item_t random_date();
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
    int unsigned add_days;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    yr  = $urandom_range(0, 9999);
    mon = $urandom_range(1, 12);
    dy  = $urandom_range(1, days_in_month(is_leap_year(yr), mon - 1));
    case ($urandom_range(0, 2))
      0:       add_days = $urandom_range(0, 400);
      1:       add_days = $urandom_range(0, 40000);
      default: add_days = $urandom & ((1 << ADD_W) - 1);
    endcase
    if (sel inside {6, 7}) begin
      // Late years, where large counts run past the last year.
      yr = $urandom_range(9000, 9999);
    end else if (sel == 8) begin
      yr       = $urandom_range(0, (1 << YEAR_W) - 1);
      mon      = $urandom_range(0, (1 << MON_W) - 1);
      dy       = $urandom_range(0, (1 << DAY_W) - 1);
      add_days = $urandom & ((1 << ADD_W) - 1);
    end else if (sel == 9) begin
      // Month-end days, including ones past the end of February.
      mon = $urandom_range(1, 3);
      dy  = $urandom_range(28, 31);
    end
    return make_date(yr, mon, dy, add_days);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-zero and all-one fields, and the two ends of the valid date range.
  task automatic test_field_extremes();
    send_date(make_date(0, 1, 1, 0));
    send_date(make_date(0, 0, 0, 0));
    send_date(make_date(0, 1, 1, (1 << ADD_W) - 1));
    send_date(make_date(9999, 12, 31, 0));
    send_date(make_date((1 << YEAR_W) - 1, (1 << MON_W) - 1, (1 << DAY_W) - 1,
                        (1 << ADD_W) - 1));
    send_date(make_date(8192, 1, 1, 0));
  endtask

  // Month zero and months above twelve are clamped; a zero day becomes the
  // first; a day past the end of its month rolls into the next months.
  task automatic test_month_and_day_clamp();
    send_date(make_date(2023, 0, 15, 10));
    send_date(make_date(2023, 13, 1, 0));
    send_date(make_date(2023, 15, 31, 1));
    send_date(make_date(2023, 6, 0, 0));
    send_date(make_date(2023, 2, 31, 0));
    send_date(make_date(2024, 2, 31, 0));
    send_date(make_date(2023, 4, 31, 0));
  endtask

  // Century years are common unless divisible by 400; year zero is leap.
  task automatic test_leap_rules();
    send_date(make_date(1900, 2, 28, 1));
    send_date(make_date(2000, 2, 28, 1));
    send_date(make_date(0, 2, 28, 1));
    send_date(make_date(2100, 2, 28, 1));
    send_date(make_date(1999, 12, 31, 1));
    send_date(make_date(2024, 1, 1, 365));
    send_date(make_date(2023, 1, 1, 365));
  endtask

  // Results past the last year, and start years above the range.
  task automatic test_year_overflow();
    send_date(make_date(9999, 12, 31, 1));
    send_date(make_date(9999, 1, 1, 364));
    send_date(make_date(9999, 1, 1, 365));
    send_date(make_date(9998, 12, 31, 365));
    send_date(make_date(10000, 1, 1, 0));
    send_date(make_date(9000, 6, 15, (1 << ADD_W) - 1));
  endtask

  task automatic test_random_dates(int unsigned count);
    repeat (count) send_date(random_date());
  endtask

  // The sender stops until every outstanding date is back, then resumes.
  task automatic test_pause_until_drained();
    wait_until_drained();
    repeat (5) send_date(random_date());
  endtask

  // Final stretch with both channels running without idle cycles.
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (25) send_date(random_date());
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_month_and_day_clamp();
    test_leap_rules();
    test_year_overflow();
    test_random_dates(42);
    test_pause_until_drained();
    test_random_dates(42);
    test_back_to_back();

    // Wait for the last dates, then watch a full latency for strays.
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/cda_pkg.sv
rtl/cda_in_if.sv
rtl/cda_out_if.sv
rtl/calendar_date_add_days.sv
sim/tb_calendar_date_add_days.sv
